// File: rtl/phi4_lattice_leapfrog_unit_defines.svh
// ----------------------------------------------------------------------------
// phi4 lattice leapfrog unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef PHI4_LATTICE_LEAPFROG_UNIT_DEFINES_SVH
`define PHI4_LATTICE_LEAPFROG_UNIT_DEFINES_SVH

// same-cycle implication
`define PHI4LL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHI4LL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/phi4ll_pkg.sv
// ----------------------------------------------------------------------------
// phi4ll_pkg
// Types, sizes, state codes and arithmetic helpers of the leapfrog unit.
// ----------------------------------------------------------------------------
package phi4ll_pkg;

  localparam int SIDE_W = 3;                  // log2 of sites per axis
  localparam int DIMS   = 4;
  localparam int SITE_W = SIDE_W * DIMS;      // 12
  localparam int NBR_W  = 4;                  // read slot: self + 2*DIMS neighbors
  localparam int NBR_N  = 2 * DIMS + 1;
  localparam int ACC_W  = 32 + 3;             // sum of 2*DIMS fields

  localparam logic [1:0] CMD_WR_FIELD = 2'd0;
  localparam logic [1:0] CMD_WR_MOM   = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_NUM_STEPS = 2'd1;
  localparam logic [1:0] REG_HOPPING   = 2'd2;
  localparam logic [1:0] REG_QUARTIC   = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [SITE_W-1:0]  site;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [SITE_W-1:0]  site_out;
    logic signed [31:0] field_out;
    logic signed [31:0] momentum_out;
    logic               saturated;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RESP,
    ST_FRD, ST_FM1, ST_FM2, ST_FM3, ST_FM4, ST_FWR,
    ST_URD, ST_UMUL, ST_UWR,
    ST_PRD, ST_PMUL, ST_PWR
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] x);
    return (x > 64'sd2147483647) || (x < -64'sd2147483648);
  endfunction

  // slot 0 is the site itself; slots 1..8 walk up/down per axis with wrap
  function automatic logic [SITE_W-1:0] nbr(input logic [SITE_W-1:0] i,
                                            input logic [NBR_W-1:0] k);
    logic [NBR_W-1:0]  s;
    int                sh;
    logic [SIDE_W-1:0] c;
    logic [SIDE_W-1:0] cn;
    logic [SITE_W-1:0] msk;
    s   = k - NBR_W'(1);
    sh  = int'(s >> 1) * SIDE_W;
    c   = SIDE_W'(i >> sh);
    cn  = s[0] ? c - SIDE_W'(1) : c + SIDE_W'(1);
    msk = SITE_W'({SIDE_W{1'b1}}) << sh;
    if (k == '0) return i;
    return (i & ~msk) | (SITE_W'(cn) << sh);
  endfunction

endpackage

// File: rtl/phi4_lattice_leapfrog_unit.sv
// ----------------------------------------------------------------------------
// phi4_lattice_leapfrog_unit
// Leapfrog trajectory engine for a phi^4 field on an 8^4 periodic lattice.
// ----------------------------------------------------------------------------
// Field, momentum and force live in three 4096 x 32 synchronous RAMs. Host
// beats (start while !busy) write one site, read one site, or run a full
// trajectory. Every beat gives exactly one result beat, shown for one cycle
// with done high; the receiver cannot stall it, so it must take it then.
// Site writes and reads go from ST_IDLE to ST_RESP, where a read shows the
// registered RAM output. A run walks all sites per half step, one site at a
// time: a force pass makes 9 field reads on the one read port for site and
// neighbors plus a state to take the last read, then 4 registered multiplies
// and the write; a momentum update reads, multiplies and writes each site,
// and so does a field update. A run makes N + 1 force passes and momentum
// updates and N field updates for N = num_steps (0 counts as 1).
// saturated reports whether any clamp fired during the last run; it is
// cleared when a run starts. Write configuration only while idle; the
// registers are not locked during a run.
// ----------------------------------------------------------------------------
`include "phi4_lattice_leapfrog_unit_defines.svh"

module phi4_lattice_leapfrog_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  phi4ll_pkg::item_t         item,
  output logic                      done,
  output phi4ll_pkg::result_t       result,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [27:0]               cfg_data
);
  import phi4ll_pkg::*;

  // config
  logic [24:0] step_size;
  logic [10:0] num_steps;
  logic [25:0] hopping;
  logic [27:0] quartic;

  state_t state, state_next;

  logic [SITE_W-1:0] idx;        // site walked by the sequencer
  logic [NBR_W-1:0]  slot;       // neighbor read slot
  logic [10:0]       steps;      // field steps done
  logic              half;       // current momentum step is a half step
  logic              last_mom;   // final half step of the trajectory
  logic              sat_flag;
  logic              rsp_rd;
  logic [SITE_W-1:0] rsp_site;

  // datapath registers
  logic signed [31:0]      phi, p2, tq, qq;
  logic signed [ACC_W-1:0] acc;
  logic signed [39:0]      hh;
  logic signed [39:0]      dd;

  // RAM ports
  logic              f_we, m_we, g_we, f_re, m_re, g_re;
  logic [SITE_W-1:0] f_wa, m_wa, f_ra, m_ra;
  logic [31:0]       f_wd, m_wd, g_wd, f_q, m_q, g_q;

  logic accept;
  logic last_site;
  logic [10:0] n_eff;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign last_site = (idx == {SITE_W{1'b1}});
  assign n_eff     = (num_steps == '0) ? 11'd1 : num_steps;

  phi4ll_ram #(.ADDR_W(SITE_W), .DATA_W(32)) u_field (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .re(f_re), .raddr(f_ra), .rdata(f_q));
  phi4ll_ram #(.ADDR_W(SITE_W), .DATA_W(32)) u_mom (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .re(m_re), .raddr(m_ra), .rdata(m_q));
  phi4ll_ram #(.ADDR_W(SITE_W), .DATA_W(32)) u_force (
    .clk, .we(g_we), .waddr(idx), .wdata(g_wd), .re(g_re), .raddr(idx), .rdata(g_q));

  // arithmetic between registers
  logic signed [63:0] prod_pp, prod_t, prod_q, prod_h, sum_f, prod_d, upd_m, upd_f;
  logic signed [32:0] p2_off;
  logic signed [57:0] prod_e;

  always_comb begin
    p2_off  = 33'(p2) - 33'sd16777216;
    prod_pp = 64'(phi) * 64'(phi);
    prod_t  = 64'($signed({1'b0, quartic})) * 64'(p2_off);
    prod_q  = 64'(tq) * 64'(phi);
    prod_h  = 64'($signed({1'b0, hopping})) * 64'(acc);
    sum_f   = -(64'(hh) <<< 1) + (64'(phi) <<< 1) + (64'(qq) <<< 2);
    prod_e  = $signed({1'b0, step_size}) * ((state == ST_UMUL) ? $signed(g_q) : $signed(m_q));
    prod_d  = half && (state == ST_UMUL) ? ((64'(prod_e) + 64'sd16777216) >>> 25)
                                         : ((64'(prod_e) + 64'sd8388608) >>> 24);
    upd_m   = 64'($signed(m_q)) - 64'(dd);
    upd_f   = 64'($signed(f_q)) + 64'(dd);
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    f_we = 1'b0; m_we = 1'b0; g_we = 1'b0;
    f_re = 1'b0; m_re = 1'b0; g_re = 1'b0;
    f_wa = idx;  m_wa = idx;
    f_ra = idx;  m_ra = idx;
    f_wd = sat32(upd_f);
    m_wd = sat32(upd_m);
    g_wd = sat32(sum_f);
    case (state)
      ST_IDLE: begin
        f_ra = item.site; m_ra = item.site;
        f_wa = item.site; m_wa = item.site;
        f_wd = item.value; m_wd = item.value;
        if (accept) begin
          case (item.command)
            CMD_WR_FIELD: begin f_we = 1'b1; state_next = ST_RESP; end
            CMD_WR_MOM:   begin m_we = 1'b1; state_next = ST_RESP; end
            CMD_RUN:      state_next = ST_FRD;
            default: begin
              f_re = 1'b1; m_re = 1'b1; state_next = ST_RESP;
            end
          endcase
        end
      end
      ST_RESP: state_next = ST_IDLE;
      ST_FRD: begin
        f_ra = nbr(idx, slot);
        f_re = (slot < NBR_W'(NBR_N));
        if (slot == NBR_W'(NBR_N)) state_next = ST_FM1;
      end
      ST_FM1: state_next = ST_FM2;
      ST_FM2: state_next = ST_FM3;
      ST_FM3: state_next = ST_FM4;
      ST_FM4: state_next = ST_FWR;
      ST_FWR: begin
        g_we = 1'b1;
        state_next = last_site ? ST_URD : ST_FRD;
      end
      ST_URD: begin
        g_re = 1'b1; m_re = 1'b1; state_next = ST_UMUL;
      end
      ST_UMUL: state_next = ST_UWR;
      ST_UWR: begin
        m_we = 1'b1;
        if (!last_site) state_next = ST_URD;
        else if (last_mom) state_next = ST_RESP;
        else state_next = ST_PRD;
      end
      ST_PRD: begin
        f_re = 1'b1; m_re = 1'b1; state_next = ST_PMUL;
      end
      ST_PMUL: state_next = ST_PWR;
      ST_PWR: begin
        f_we = 1'b1;
        state_next = last_site ? ST_FRD : ST_PRD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= 25'd1677722;
      num_steps <= 11'd10;
      hopping   <= 26'd3355443;
      quartic   <= 28'd16777216;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_SIZE: step_size <= cfg_data[24:0];
        REG_NUM_STEPS: num_steps <= cfg_data[10:0];
        REG_HOPPING:   hopping   <= cfg_data[25:0];
        REG_QUARTIC:   quartic   <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; slot <= '0; steps <= '0;
      half <= 1'b1; last_mom <= 1'b0; sat_flag <= 1'b0;
      rsp_rd <= 1'b0; rsp_site <= '0;
    end else begin
      case (state)
        ST_IDLE: if (accept) begin
          rsp_rd   <= (item.command == CMD_READ);
          rsp_site <= item.site;
          if (item.command == CMD_RUN) begin
            sat_flag <= 1'b0; idx <= '0; slot <= '0; steps <= '0;
            half <= 1'b1; last_mom <= 1'b0;
          end
        end
        ST_FRD: slot <= (slot == NBR_W'(NBR_N)) ? '0 : slot + NBR_W'(1);
        ST_FM1: if (sat_hit((prod_pp + 64'sd8388608) >>> 24)) sat_flag <= 1'b1;
        ST_FM2: if (sat_hit((prod_t + 64'sd8388608) >>> 24)) sat_flag <= 1'b1;
        ST_FM3: if (sat_hit((prod_q + 64'sd8388608) >>> 24)) sat_flag <= 1'b1;
        ST_FWR: begin
          if (sat_hit(sum_f)) sat_flag <= 1'b1;
          idx <= idx + SITE_W'(1);
        end
        ST_UWR: begin
          if (sat_hit(upd_m)) sat_flag <= 1'b1;
          idx <= idx + SITE_W'(1);
        end
        ST_PWR: begin
          if (sat_hit(upd_f)) sat_flag <= 1'b1;
          idx <= idx + SITE_W'(1);
          if (last_site) begin
            steps <= steps + 11'd1;
            if (steps + 11'd1 >= n_eff) begin
              half <= 1'b1; last_mom <= 1'b1;
            end else begin
              half <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // force datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_FRD: begin
        if (slot == NBR_W'(1)) begin
          phi <= f_q;
          acc <= '0;
        end else if (slot > NBR_W'(1)) begin
          acc <= acc + ACC_W'($signed(f_q));
        end
      end
      ST_FM1: p2 <= sat32((prod_pp + 64'sd8388608) >>> 24);
      ST_FM2: tq <= sat32((prod_t + 64'sd8388608) >>> 24);
      ST_FM3: qq <= sat32((prod_q + 64'sd8388608) >>> 24);
      ST_FM4: hh <= 40'((prod_h + 64'sd8388608) >>> 24);
      ST_UMUL, ST_PMUL: dd <= 40'(prod_d);
      default: ;
    endcase
  end

  // result beat
  assign done                = (state == ST_RESP);
  assign result.site_out     = rsp_rd ? rsp_site : '0;
  assign result.field_out    = rsp_rd ? $signed(f_q) : '0;
  assign result.momentum_out = rsp_rd ? $signed(m_q) : '0;
  assign result.saturated    = sat_flag;

  `PHI4LL_ASSERT_NOW(a_done_busy, done, busy, "result beat outside a busy phase")
  `PHI4LL_ASSERT_NEXT(a_done_single, done, !done, "result beat longer than one cycle")
  `PHI4LL_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
  `PHI4LL_ASSERT_NOW(a_idle_nowrite, !busy && !accept, !f_we && !m_we && !g_we,
                     "RAM write while idle")
endmodule

// File: rtl/phi4ll_ram.sv
// ----------------------------------------------------------------------------
// phi4ll_ram
// Simple dual-port synchronous RAM, registered read with enable.
// ----------------------------------------------------------------------------
module phi4ll_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: phi4 lattice leapfrog unit testbench
// Loads every site, runs leapfrog trajectories under several coupling sets and
// checks each result beat against an in-bench lattice integrator.
// ----------------------------------------------------------------------------
module tb_top;
  import phi4ll_pkg::*;

  localparam int NSITE     = 4096;
  localparam int SIDE      = 8;
  localparam int WDOG_MAX  = 1000000;   // longer than the slowest run's busy time
  localparam int N_RANDOM  = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [27:0] cfg_data = '0;

  phi4_lattice_leapfrog_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lattice mirror: field, momentum, force and the clamp flag
  int   lat_phi [NSITE];
  int   lat_mom [NSITE];
  int   lat_frc [NSITE];
  bit   lat_sat;
  // coupling mirror
  longint eps_q, kappa_q, lambda_q;
  int     n_steps;

  item_t   pending_items[$];
  result_t expected_beats[$];
  item_t   cur_item;
  bit      quiet = 1'b1;      // no idling while set
  bit      failed = 1'b0;
  int      idle_cnt = 0;

  // round half up, Q8.24 product back to Q8.24 (or eps/2 with sh = 25)
  function automatic longint round_shift(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) begin
      lat_sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      lat_sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  function automatic int wrap_nbr(int i, int stride, bit up);
    int c;
    c = (i / stride) % SIDE;
    if (up) return ((c == SIDE - 1) ? i - (SIDE - 1) * stride : i + stride) % NSITE;
    return ((c == 0) ? i + (SIDE - 1) * stride : i - stride) % NSITE;
  endfunction

  function automatic void drift_field();
    for (int i = 0; i < NSITE; i++)
      lat_phi[i] = clamp32(longint'(lat_phi[i]) + round_shift(eps_q * lat_mom[i], 24));
  endfunction

  // forces all from the field as it stands, then the kick
  function automatic void kick_momentum(int sh);
    longint a, phi, p2, t, q, h;
    int stride;
    for (int i = 0; i < NSITE; i++) begin
      a = 0;
      stride = 1;
      phi = lat_phi[i];
      for (int mu = 0; mu < 4; mu++) begin
        a += lat_phi[wrap_nbr(i, stride, 1'b1)];
        a += lat_phi[wrap_nbr(i, stride, 1'b0)];
        stride *= SIDE;
      end
      p2 = clamp32(round_shift(phi * phi, 24));
      t  = clamp32(round_shift(lambda_q * (p2 - (longint'(1) << 24)), 24));
      q  = clamp32(round_shift(t * phi, 24));
      h  = round_shift(kappa_q * a, 24);
      lat_frc[i] = clamp32(-2 * h + 2 * phi + 4 * q);
    end
    for (int i = 0; i < NSITE; i++)
      lat_mom[i] = clamp32(longint'(lat_mom[i]) - round_shift(eps_q * lat_frc[i], sh));
  endfunction

  function automatic void leapfrog_trajectory();
    int n;
    n = (n_steps == 0) ? 1 : n_steps;
    lat_sat = 1'b0;
    kick_momentum(25);
    for (int k = 1; k < n; k++) begin
      drift_field();
      kick_momentum(24);
    end
    drift_field();
    kick_momentum(25);
  endfunction

  function automatic result_t lattice_response(item_t it);
    result_t r;
    r = '0;
    case (it.command)
      CMD_WR_FIELD: lat_phi[it.site] = it.value;
      CMD_WR_MOM:   lat_mom[it.site] = it.value;
      CMD_RUN:      leapfrog_trajectory();
      default: begin
        r.site_out     = it.site;
        r.field_out    = lat_phi[it.site];
        r.momentum_out = lat_mom[it.site];
      end
    endcase
    r.saturated = lat_sat;
    return r;
  endfunction

  // driver: start held until the beat is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_beats.push_back(lattice_response(cur_item));
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
          cur_item = pending_items.pop_front();
          item  <= cur_item;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, so take them as they show
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_beats.pop_front();
        if (result.site_out !== e.site_out) begin
          $error("site_out exp %0d got %0d", e.site_out, result.site_out);
          failed = 1'b1;
        end
        if (result.field_out !== e.field_out) begin
          $error("field_out exp %0d got %0d", e.field_out, result.field_out);
          failed = 1'b1;
        end
        if (result.momentum_out !== e.momentum_out) begin
          $error("momentum_out exp %0d got %0d", e.momentum_out, result.momentum_out);
          failed = 1'b1;
        end
        if (result.saturated !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, result.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic set_reg(logic [1:0] idx, logic [27:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_STEP_SIZE: eps_q    = val[24:0];
      REG_NUM_STEPS: n_steps  = val[10:0];
      REG_HOPPING:   kappa_q  = val[25:0];
      default:       lambda_q = val[27:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(logic [1:0] cmd, int site, int val);
    item_t it;
    it.command = cmd;
    it.site    = site[11:0];
    it.value   = val;
    pending_items.push_back(it);
  endtask

  // every beat in and out, then a short settle
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || start || expected_beats.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return int'($urandom_range(0, 1 << 25)) - (1 << 24);   // about +-1.0
      2:       return int'($urandom_range(0, 1 << 27)) - (1 << 26);   // about +-4.0
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_beats(int count);
    int c;
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(0, 2);
      if (c == 0) push_item(CMD_WR_FIELD, $urandom_range(0, NSITE - 1), pick_value());
      else if (c == 1) push_item(CMD_WR_MOM, $urandom_range(0, NSITE - 1), pick_value());
      else push_item(CMD_READ, $urandom_range(0, NSITE - 1), $urandom);
    end
  endtask

  initial begin
    eps_q = 1677722; n_steps = 10; kappa_q = 3355443; lambda_q = 16777216;
    lat_sat = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // load every site with small values, no idling
    for (int s = 0; s < NSITE; s++) begin
      push_item(CMD_WR_FIELD, s, int'($urandom_range(0, 1 << 24)) - (1 << 23));
      push_item(CMD_WR_MOM, s, int'($urandom_range(0, 1 << 24)) - (1 << 23));
    end
    drain();

    // zero steps acts as one; reset couplings, small field
    set_reg(REG_NUM_STEPS, 28'd1024);
    set_reg(REG_NUM_STEPS, 28'd0);
    push_item(CMD_RUN, 0, 0);
    push_item(CMD_READ, 0, 0);
    push_item(CMD_READ, NSITE - 1, 0);
    drain();
    quiet = 1'b0;

    // directed extremes
    push_item(CMD_WR_FIELD, 0, 32'sh7fffffff);
    push_item(CMD_WR_MOM, 0, 32'sh80000000);
    push_item(CMD_WR_FIELD, NSITE - 1, 32'sh80000000);
    push_item(CMD_WR_MOM, NSITE - 1, 32'sh7fffffff);
    push_item(CMD_READ, 0, 32'sh7fffffff);
    push_item(CMD_READ, NSITE - 1, 32'sh80000000);
    push_item(CMD_WR_FIELD, 1365, 0);
    push_item(CMD_WR_MOM, 2730, -1);
    push_item(CMD_READ, 1365, 0);
    push_item(CMD_READ, 2730, 0);
    random_beats(N_RANDOM);
    drain();

    // strong couplings, a step of 1.0: clamps fire
    set_reg(REG_STEP_SIZE, 28'd16777216);
    set_reg(REG_HOPPING, 28'd33554432);
    set_reg(REG_QUARTIC, 28'd167772160);
    set_reg(REG_NUM_STEPS, 28'd2);
    push_item(CMD_RUN, 0, 0);
    random_beats(40);
    drain();

    // zero step and couplings; flag restarts with the run
    set_reg(REG_STEP_SIZE, 28'd0);
    set_reg(REG_HOPPING, 28'd0);
    set_reg(REG_QUARTIC, 28'd0);
    set_reg(REG_NUM_STEPS, 28'd1);
    for (int s = 0; s < 16; s++) push_item(CMD_WR_FIELD, $urandom_range(0, NSITE - 1), 0);
    push_item(CMD_RUN, 0, 0);
    random_beats(40);
    drain();
    repeat (20) @(posedge clk);

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
